>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define URFRD_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("urfrd assertion failed");

// Next-cycle implication.
`define URFRD_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("urfrd assertion failed");

`endif

>>> rtl/urfrd_pkg.sv
// ----------------------------------------------------------------------------
// urfrd_pkg
// Widths, register indexes and shared types of the uniform range sampler.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package urfrd_pkg;

  localparam int VAL_W     = 31;
  localparam int DIGIT_W   = 8;
  localparam int BASE_W    = 9;
  localparam int CFG_IDX_W = 2;
  localparam int DIV_CNT_W = 5;

  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_SIZE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DIGIT_BASE = 2'd1;

  typedef enum logic [1:0] {
    ST_INIT,
    ST_LOAD,
    ST_WAIT,
    ST_RUN
  } state_t;

  typedef struct packed {
    logic              start;
    logic [VAL_W-1:0]  dividend;
    logic [BASE_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic               busy;
    logic               done;
    logic [VAL_W-1:0]   quot;
    logic [DIGIT_W-1:0] rem;
  } div_stat_t;

endpackage

>>> rtl/urfrd_in_if.sv
// ----------------------------------------------------------------------------
// urfrd_in_if
// Input channel: one random digit per word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface urfrd_in_if;
  logic                        valid;
  logic                        ready;
  logic [urfrd_pkg::DIGIT_W-1:0] random_digit;

  modport source (output valid, output random_digit, input ready);
  modport sink   (input valid, input random_digit, output ready);
endinterface

>>> rtl/urfrd_out_if.sv
// ----------------------------------------------------------------------------
// urfrd_out_if
// Result channel: one uniform value per word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface urfrd_out_if;
  logic                        valid;
  logic                        ready;
  logic [urfrd_pkg::VAL_W-1:0] random_value;

  modport source (output valid, output random_value, input ready);
  modport sink   (input valid, input random_value, output ready);
endinterface

>>> rtl/urfrd_cfg_if.sv
// ----------------------------------------------------------------------------
// urfrd_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface urfrd_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [urfrd_pkg::CFG_IDX_W-1:0] index;
  logic [urfrd_pkg::VAL_W-1:0]     value;

  modport source (output valid, output index, output value, input ready);
  modport sink   (input valid, input index, input value, output ready);
endinterface

>>> rtl/urfrd_div.sv
// ----------------------------------------------------------------------------
// urfrd_div
// Serial restoring divider, one quotient bit per cycle, for bound digits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module urfrd_div (
  input  logic                 clk,
  input  logic                 rst_n,
  input  urfrd_pkg::div_req_t  req,
  output urfrd_pkg::div_stat_t stat
);

  localparam logic [urfrd_pkg::DIV_CNT_W-1:0] CNT_LAST =
    urfrd_pkg::DIV_CNT_W'(urfrd_pkg::VAL_W - 1);

  logic                              busy_r;
  logic                              done_r;
  logic [urfrd_pkg::DIV_CNT_W-1:0]   cnt_r;
  logic [urfrd_pkg::VAL_W-1:0]       dvd_r;
  logic [urfrd_pkg::DIGIT_W-1:0]     rem_r;
  logic [urfrd_pkg::BASE_W-1:0]      dvs_r;

  logic [urfrd_pkg::BASE_W-1:0]      shifted;
  logic [urfrd_pkg::BASE_W-1:0]      diff;
  logic                              fits;

  always_comb begin
    shifted = {rem_r, dvd_r[urfrd_pkg::VAL_W-1]};
    diff    = shifted - dvs_r;
    fits    = shifted >= dvs_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else if (req.start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
    end else if (busy_r) begin
      if (cnt_r == CNT_LAST) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd_r <= req.dividend;
      dvs_r <= req.divisor;
      rem_r <= '0;
      cnt_r <= '0;
    end else if (busy_r) begin
      // The remainder stays below the divisor, so eight bits hold it.
      rem_r <= fits ? diff[urfrd_pkg::DIGIT_W-1:0] : shifted[urfrd_pkg::DIGIT_W-1:0];
      dvd_r <= {dvd_r[urfrd_pkg::VAL_W-2:0], fits};
      cnt_r <= cnt_r + 1'b1;
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign stat.quot = dvd_r;
  assign stat.rem  = rem_r;

endmodule

>>> rtl/uniform_range_from_random_digits.sv
// ----------------------------------------------------------------------------
// uniform_range_from_random_digits
// Uniform integer in 1..range_size from uniform base digit_base digits.
// ----------------------------------------------------------------------------
// The block takes one random digit per cycle while the output is not stalled
// and gives one value each time a rejection sampling attempt against the
// digits of range_size-1 succeeds. A digit passes from the input register
// s1_digit_r to the result register out_value_r when it advances, so digits
// can stream in at one per cycle while the output drains; a stalled output
// holds intake only once the input register is full. After reset and after
// every write to range_size or digit_base the bound digits are derived by a
// serial divider that makes one quotient bit per cycle: a setup step comes
// first, then each digit costs a load step, the quotient bits and a store
// step. During the derivation in_ch.ready is low. A range_size of one gives
// 1 for every digit.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module uniform_range_from_random_digits #(
  parameter int MAX_DIGITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  urfrd_in_if.sink    in_ch,
  urfrd_out_if.source out_ch,
  urfrd_cfg_if.sink   cfg_ch
);

  localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam int POS_W = $clog2(MAX_DIGITS + 1);
  localparam logic [POS_W-1:0] MAX_POS  = POS_W'(MAX_DIGITS);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_DIGITS - 1);

  // Configuration registers and derivation control.
  urfrd_pkg::state_t             state_r, state_nxt;
  logic [urfrd_pkg::VAL_W-1:0]   range_r;
  logic [urfrd_pkg::BASE_W-1:0]  base_r;
  logic [urfrd_pkg::VAL_W-1:0]   v_r;
  logic [IDX_W-1:0]              idx_r;
  logic [POS_W-1:0]              first_r;
  logic [urfrd_pkg::DIGIT_W-1:0] bound_r [MAX_DIGITS];

  // Attempt state and the two pipeline registers.
  logic [POS_W-1:0]              pos_r;
  logic                          tight_r;
  logic [urfrd_pkg::VAL_W-1:0]   part_r;
  logic                          s1_valid_r;
  logic [urfrd_pkg::DIGIT_W-1:0] s1_digit_r;
  logic                          out_valid_r;
  logic [urfrd_pkg::VAL_W-1:0]   out_value_r;

  urfrd_pkg::div_req_t           div_req;
  urfrd_pkg::div_stat_t          div_stat;

  logic                          cfg_wr;
  logic                          cfg_reg_wr;
  logic                          run;
  logic                          store;
  logic [urfrd_pkg::BASE_W-1:0]  base_eff;
  logic [urfrd_pkg::VAL_W-1:0]   range_m1;
  logic [POS_W-1:0]              first_upd;

  logic                          adv;
  logic [urfrd_pkg::DIGIT_W-1:0] bound_sel;
  logic [urfrd_pkg::VAL_W+urfrd_pkg::BASE_W-1:0] prod;
  logic [urfrd_pkg::VAL_W-1:0]   sum;
  logic [POS_W-1:0]              pos_inc;
  logic                          range_one;
  logic                          reject;
  logic                          finish;
  logic                          emit;
  logic [urfrd_pkg::VAL_W-1:0]   emit_value;

  urfrd_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .stat  (div_stat)
  );

  assign cfg_ch.ready = 1'b1;
  assign cfg_wr       = cfg_ch.valid && cfg_ch.ready;
  // Only a write that hits a register derives the bound again.
  assign cfg_reg_wr   = cfg_wr && ((cfg_ch.index == urfrd_pkg::CFG_RANGE_SIZE) ||
                                   (cfg_ch.index == urfrd_pkg::CFG_DIGIT_BASE));

  always_comb begin
    if (base_r < urfrd_pkg::BASE_W'(2)) begin
      base_eff = urfrd_pkg::BASE_W'(2);
    end else if (base_r > urfrd_pkg::BASE_W'(256)) begin
      base_eff = urfrd_pkg::BASE_W'(256);
    end else begin
      base_eff = base_r;
    end
    range_m1  = (range_r == '0) ? '0 : range_r - 1'b1;
    first_upd = (div_stat.rem != '0) ? POS_W'(idx_r) : first_r;
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      urfrd_pkg::ST_INIT: begin
        state_nxt = urfrd_pkg::ST_LOAD;
      end
      urfrd_pkg::ST_LOAD: begin
        state_nxt = urfrd_pkg::ST_WAIT;
      end
      urfrd_pkg::ST_WAIT: begin
        if (div_stat.done) begin
          state_nxt = (idx_r == '0) ? urfrd_pkg::ST_RUN : urfrd_pkg::ST_LOAD;
        end
      end
      urfrd_pkg::ST_RUN: begin
        state_nxt = urfrd_pkg::ST_RUN;
      end
      default: begin
        state_nxt = urfrd_pkg::ST_INIT;
      end
    endcase
    if (cfg_reg_wr) begin
      state_nxt = urfrd_pkg::ST_INIT;
    end
  end

  // State outputs.
  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = v_r;
    div_req.divisor  = base_eff;
    run              = 1'b0;
    store            = 1'b0;
    case (state_r)
      urfrd_pkg::ST_LOAD: div_req.start = 1'b1;
      urfrd_pkg::ST_WAIT: store = div_stat.done;
      urfrd_pkg::ST_RUN:  run = 1'b1;
      default: begin
        run = 1'b0;
      end
    endcase
  end

  // One digit of the attempt.
  always_comb begin
    bound_sel  = bound_r[pos_r[IDX_W-1:0]];
    prod       = part_r * base_eff;
    sum        = prod[urfrd_pkg::VAL_W-1:0] + urfrd_pkg::VAL_W'(s1_digit_r);
    pos_inc    = pos_r + 1'b1;
    range_one  = (first_r == MAX_POS);
    // A digit at or above the base counts as a rejection like an oversized one.
    reject     = ({1'b0, s1_digit_r} >= base_eff) || (tight_r && (s1_digit_r > bound_sel));
    finish     = !reject && (pos_inc == MAX_POS);
    emit       = range_one || finish;
    emit_value = range_one ? urfrd_pkg::VAL_W'(1) : sum + 1'b1;
  end

  assign adv          = run && s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = run && (!s1_valid_r || adv);
  assign out_ch.valid = out_valid_r;
  assign out_ch.random_value = out_value_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= urfrd_pkg::ST_INIT;
      range_r     <= urfrd_pkg::VAL_W'(1);
      base_r      <= urfrd_pkg::BASE_W'(2);
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr) begin
        case (cfg_ch.index)
          urfrd_pkg::CFG_RANGE_SIZE: range_r <= cfg_ch.value;
          urfrd_pkg::CFG_DIGIT_BASE: base_r  <= cfg_ch.value[urfrd_pkg::BASE_W-1:0];
          default: begin
            range_r <= range_r;
          end
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        s1_valid_r <= 1'b1;
      end else if (adv) begin
        s1_valid_r <= 1'b0;
      end
      if (adv && emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == urfrd_pkg::ST_INIT) begin
      v_r     <= range_m1;
      idx_r   <= IDX_LAST;
      first_r <= MAX_POS;
    end
    if (store) begin
      // Digits come out least significant first, so the index counts down.
      bound_r[idx_r] <= div_stat.rem;
      v_r            <= div_stat.quot;
      first_r        <= first_upd;
      if (idx_r != '0) begin
        idx_r <= idx_r - 1'b1;
      end else begin
        pos_r   <= first_upd;
        tight_r <= 1'b1;
        part_r  <= '0;
      end
    end
    if (adv && !range_one) begin
      if (reject || finish) begin
        pos_r   <= first_r;
        tight_r <= 1'b1;
        part_r  <= '0;
      end else begin
        pos_r   <= pos_inc;
        tight_r <= tight_r && (s1_digit_r == bound_sel);
        part_r  <= sum;
      end
    end
    if (in_ch.valid && in_ch.ready) begin
      s1_digit_r <= in_ch.random_digit;
    end
    if (adv && emit) begin
      out_value_r <= emit_value;
    end
  end

  `URFRD_ASSERT_IMP(a_value_nonzero, out_valid_r, out_value_r != '0)
  `URFRD_ASSERT_IMP(a_pos_in_range, run && (first_r != MAX_POS),
                    (pos_r >= first_r) && (pos_r < MAX_POS))
  `URFRD_ASSERT_IMP(a_ready_only_running, in_ch.ready, run && !div_stat.busy)
  `URFRD_ASSERT_NXT(a_cfg_stops_intake, cfg_reg_wr, !in_ch.ready)

endmodule
